@@ src/cbe_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbe_pkg: shared definitions for the cubic bezier easing pipeline
// widths, fixed-point constants, register indexes and the search item type
// ----------------------------------------------------------------------------
package cbe_pkg;

	// fixed point and search depth
	localparam int FRAC_BITS       = 16;
	localparam int BISECTION_STEPS = 14;

	// field widths
	localparam int XW = 17;               // unsigned q1.16 progress and x controls
	localparam int YW = 20;               // signed q3.16 y controls and result
	localparam int TW = FRAC_BITS + 1;    // curve parameter, holds one itself

	// derived datapath widths
	localparam int X3W = XW + 2;          // three times an x control
	localparam int Y3W = YW + 2;          // three times a y control
	localparam int PXW = TW + X3W;        // weight times x control
	localparam int XSW = PXW + 2;         // x sum
	localparam int PYW = TW + 1 + Y3W;    // weight times y control, signed
	localparam int YSW = PYW + 2;         // y sum, signed

	localparam logic [TW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	// configuration port
	localparam int CFG_IW = 2;
	localparam logic [CFG_IW-1:0] REG_CONTROL1_X = 2'd0;
	localparam logic [CFG_IW-1:0] REG_CONTROL1_Y = 2'd1;
	localparam logic [CFG_IW-1:0] REG_CONTROL2_X = 2'd2;
	localparam logic [CFG_IW-1:0] REG_CONTROL2_Y = 2'd3;

	localparam logic [XW-1:0] CONTROL1_X_RESET = 17'd27525;
	localparam logic [YW-1:0] CONTROL1_Y_RESET = 20'd6554;
	localparam logic [XW-1:0] CONTROL2_X_RESET = 17'd16384;
	localparam logic [YW-1:0] CONTROL2_Y_RESET = 20'd65536;

	// one item in flight through the bisection
	typedef struct packed {
		logic          valid;
		logic [XW-1:0] progress;
		logic [TW-1:0] lo;
		logic [TW-1:0] hi;
	} search_t;

endpackage
`default_nettype wire

@@ src/cubic_bezier_easing.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bezier_easing: css-style cubic bezier timing curve
// maps linear progress to eased progress through a fixed-step bisection
// ----------------------------------------------------------------------------
// usage
//   input: a progress value (unsigned q1.16) is taken at each rising edge
//   with start high and busy low; busy is always low, so a new transfer can
//   come in every cycle
//   output: done is high for exactly one cycle with eased (signed q3.16,
//   saturated to 20 bits); the receiver cannot hold it off and needs none
//   order: results leave in the order items came in
//   throughput: one item per cycle; each bisection step is five pipeline
//   stages (midpoint, two multiplier stages for the weights, the control
//   products, the compare), the final y evaluation another five
//   config: cfg_we writes cfg_data into register cfg_index at the edge;
//   write only while no item is in flight
//   reset: arst_n clears all valid bits and loads the default control points
// ----------------------------------------------------------------------------
module cubic_bezier_easing (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [cbe_pkg::XW-1:0]      progress,
	output logic                             done,
	output logic signed [cbe_pkg::YW-1:0]    eased,
	input  wire logic                        cfg_we,
	input  wire logic [cbe_pkg::CFG_IW-1:0]  cfg_index,
	input  wire logic [cbe_pkg::YW-1:0]      cfg_data
);
	import cbe_pkg::*;

	localparam logic signed [YSW-1:0] Y_MAX = YSW'((2**(YW-1)) - 1);
	localparam logic signed [YSW-1:0] Y_MIN = YSW'(-(2**(YW-1)));

	// control point registers
	logic        [XW-1:0]  control1_x_q, control2_x_q;
	logic signed [YW-1:0]  control1_y_q, control2_y_q;
	// three-scaled copies, so the weights need no times-three in the datapath
	logic        [X3W-1:0] c1x3_q, c2x3_q;
	logic signed [Y3W-1:0] c1y3_q, c2y3_q;

	// search pipeline between steps
	search_t chain [0:BISECTION_STEPS];

	// final evaluation
	logic [TW-1:0]         ttt_f, uut_f, utt_f;
	logic                  fv_s1, fv_s2, fv_s3, fv_s4;
	logic signed [PYW-1:0] q1_s4, q2_s4;
	logic [TW-1:0]         ttt_s4;
	logic signed [YSW-1:0] y_sum, y_floor;
	logic signed [YW-1:0]  y_sat;
	logic                  done_q;
	logic signed [YW-1:0]  eased_q;

	// the pipeline never stalls
	assign busy = 1'b0;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control1_x_q <= CONTROL1_X_RESET;
			control1_y_q <= CONTROL1_Y_RESET;
			control2_x_q <= CONTROL2_X_RESET;
			control2_y_q <= CONTROL2_Y_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CONTROL1_X: control1_x_q <= cfg_data[XW-1:0];
				REG_CONTROL1_Y: control1_y_q <= cfg_data;
				REG_CONTROL2_X: control2_x_q <= cfg_data[XW-1:0];
				REG_CONTROL2_Y: control2_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// scaled controls are registered from the control registers; first use is several stages in
	always_ff @(posedge clk) begin
		c1x3_q <= X3W'(control1_x_q) + (X3W'(control1_x_q) << 1);
		c2x3_q <= X3W'(control2_x_q) + (X3W'(control2_x_q) << 1);
		c1y3_q <= Y3W'(control1_y_q) + (Y3W'(control1_y_q) << 1);
		c2y3_q <= Y3W'(control2_y_q) + (Y3W'(control2_y_q) << 1);
	end

	// search starts on the whole interval
	always_comb begin
		chain[0].valid    = start & ~busy;
		chain[0].progress = progress;
		chain[0].lo       = '0;
		chain[0].hi       = ONE;
	end

	// one step per bisection iteration
	for (genvar i = 0; i < BISECTION_STEPS; i++) begin : g_step
		cbe_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.c1x3     (c1x3_q),
			.c2x3     (c2x3_q),
			.in_item  (chain[i]),
			.out_item (chain[i+1])
		);
	end

	// weights at the final midpoint
	cbe_weights u_final_weights (
		.clk (clk),
		.lo  (chain[BISECTION_STEPS].lo),
		.hi  (chain[BISECTION_STEPS].hi),
		.t   (),
		.ttt (ttt_f),
		.uut (uut_f),
		.utt (utt_f)
	);

	// valid bits for the final evaluation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_s1  <= 1'b0;
			fv_s2  <= 1'b0;
			fv_s3  <= 1'b0;
			fv_s4  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			fv_s1  <= chain[BISECTION_STEPS].valid;
			fv_s2  <= fv_s1;
			fv_s3  <= fv_s2;
			fv_s4  <= fv_s3;
			done_q <= fv_s4;
		end
	end

	// weights times three-scaled y controls, signed
	always_ff @(posedge clk) begin
		q1_s4  <= PYW'($signed({1'b0, uut_f})) * PYW'(c1y3_q);
		q2_s4  <= PYW'($signed({1'b0, utt_f})) * PYW'(c2y3_q);
		ttt_s4 <= ttt_f;
	end

	// t^3 is weighted by one, so it is shifted up to the product scale and joins the sum before the floor shift
	assign y_sum   = YSW'(q1_s4) + YSW'(q2_s4)
	               + (YSW'($signed({1'b0, ttt_s4})) << FRAC_BITS);
	assign y_floor = y_sum >>> FRAC_BITS;

	// saturate to the 20-bit signed range
	always_comb begin
		if (y_floor > Y_MAX) begin
			y_sat = Y_MAX[YW-1:0];
		end else if (y_floor < Y_MIN) begin
			y_sat = Y_MIN[YW-1:0];
		end else begin
			y_sat = y_floor[YW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		eased_q <= y_sat;
	end

	assign done  = done_q;
	assign eased = eased_q;

endmodule
`default_nettype wire

@@ src/cbe_weights.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbe_weights: bernstein weights at the bisection midpoint
// three stages: midpoint, squares, cubes; outputs t, t^3, u^2*t, u*t^2
// ----------------------------------------------------------------------------
module cbe_weights (
	input  wire logic                  clk,
	input  wire logic [cbe_pkg::TW-1:0] lo,
	input  wire logic [cbe_pkg::TW-1:0] hi,
	output logic      [cbe_pkg::TW-1:0] t,
	output logic      [cbe_pkg::TW-1:0] ttt,
	output logic      [cbe_pkg::TW-1:0] uut,
	output logic      [cbe_pkg::TW-1:0] utt
);
	import cbe_pkg::*;

	logic [TW:0]     sum_lh;
	logic [TW-1:0]   mid;
	logic [TW-1:0]   t_s1, u_s1;
	logic [TW-1:0]   t_s2, tt_s2, ut_s2, uu_s2;
	logic [TW-1:0]   t_s3, ttt_s3, uut_s3, utt_s3;
	logic [2*TW-1:0] tt_full, ut_full, uu_full;
	logic [2*TW-1:0] ttt_full, uut_full, utt_full;

	// floor midpoint
	assign sum_lh = {1'b0, lo} + {1'b0, hi};
	assign mid    = sum_lh[TW:1];

	always_ff @(posedge clk) begin
		t_s1 <= mid;
		u_s1 <= ONE - mid;
	end

	assign tt_full = (2*TW)'(t_s1) * (2*TW)'(t_s1);
	assign ut_full = (2*TW)'(u_s1) * (2*TW)'(t_s1);
	assign uu_full = (2*TW)'(u_s1) * (2*TW)'(u_s1);

	always_ff @(posedge clk) begin
		t_s2  <= t_s1;
		tt_s2 <= tt_full[FRAC_BITS +: TW];
		ut_s2 <= ut_full[FRAC_BITS +: TW];
		uu_s2 <= uu_full[FRAC_BITS +: TW];
	end

	assign ttt_full = (2*TW)'(tt_s2) * (2*TW)'(t_s2);
	assign uut_full = (2*TW)'(uu_s2) * (2*TW)'(t_s2);
	assign utt_full = (2*TW)'(ut_s2) * (2*TW)'(t_s2);

	always_ff @(posedge clk) begin
		t_s3   <= t_s2;
		ttt_s3 <= ttt_full[FRAC_BITS +: TW];
		uut_s3 <= uut_full[FRAC_BITS +: TW];
		utt_s3 <= utt_full[FRAC_BITS +: TW];
	end

	assign t   = t_s3;
	assign ttt = ttt_s3;
	assign uut = uut_s3;
	assign utt = utt_s3;

endmodule
`default_nettype wire

@@ src/cbe_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbe_step: one bisection step of the curve parameter search
// five stages: weights (three), x products, x compare and bound update
// ----------------------------------------------------------------------------
module cbe_step (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [cbe_pkg::X3W-1:0] c1x3,
	input  wire logic [cbe_pkg::X3W-1:0] c2x3,
	input  wire cbe_pkg::search_t        in_item,
	output cbe_pkg::search_t             out_item
);
	import cbe_pkg::*;

	search_t        side_s1, side_s2, side_s3, side_s4, res_s5;
	logic [TW-1:0]  t_w, ttt_w, uut_w, utt_w;
	logic [TW-1:0]  t_s4, ttt_s4;
	logic [PXW-1:0] p1_s4, p2_s4;
	logic [XSW-1:0] x_sum, x_lim;
	logic           below;

	cbe_weights u_weights (
		.clk (clk),
		.lo  (in_item.lo),
		.hi  (in_item.hi),
		.t   (t_w),
		.ttt (ttt_w),
		.uut (uut_w),
		.utt (utt_w)
	);

	// side data rides along with the weight stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
		end else begin
			side_s1 <= in_item;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
		end
	end

	// weights times three-scaled x controls
	always_ff @(posedge clk) begin
		p1_s4  <= PXW'(uut_w) * PXW'(c1x3);
		p2_s4  <= PXW'(utt_w) * PXW'(c2x3);
		ttt_s4 <= ttt_w;
		t_s4   <= t_w;
	end

	// floor(sum / one) < progress  <=>  sum < progress * one
	assign x_sum = XSW'(p1_s4) + XSW'(p2_s4) + (XSW'(ttt_s4) << FRAC_BITS);
	assign x_lim = XSW'(side_s4.progress) << FRAC_BITS;
	assign below = x_sum < x_lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s5 <= '0;
		end else begin
			res_s5 <= side_s4;
			if (below) begin
				res_s5.lo <= t_s4;
			end else begin
				res_s5.hi <= t_s4;
			end
		end
	end

	assign out_item = res_s5;

endmodule
`default_nettype wire
